@@ rtl/ndis_pkg.sv @@
// ----------------------------------------------------------------------------
// ndis_pkg
// shared types and constants of the work-item index stepper
// ----------------------------------------------------------------------------
package ndis_pkg;

   localparam int SIZE_W    = 16;
   localparam int GLOBAL_W  = 32;
   localparam int DIM_W     = 2;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_DIMS  = 3;

   localparam logic [CFG_IDX_W-1:0] CFG_WORK_DIMS     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SIZE_X  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SIZE_Y  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SIZE_Z  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT_X = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT_Y = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT_Z = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_WAIT,
      ST_GLOB,
      ST_GADD,
      ST_FINISH
   } ndis_state_type;

   typedef struct packed {
      logic             load;
      logic             div_start;
      logic             digit_write;
      logic             set_done;
      logic             mul;
      logic             add;
      logic             out_load;
      logic             sel_group;
      logic [DIM_W-1:0] sel_dim;
   } ndis_cmd_type;

   typedef struct packed {
      logic             carry_zero;
      logic             range_done;
      logic             div_done;
      logic [DIM_W-1:0] dims;
   } ndis_status_type;

endpackage

@@ rtl/ndis_div.sv @@
// ----------------------------------------------------------------------------
// ndis_div
// restoring divider, one quotient bit per cycle, 16-bit divisor
// ----------------------------------------------------------------------------
module ndis_div #(
   parameter int DIVIDEND_W = 19
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIVIDEND_W-1:0]       dividend,
   input  logic [ndis_pkg::SIZE_W-1:0] divisor,
   output logic                        done,
   output logic [DIVIDEND_W-1:0]       quotient,
   output logic [ndis_pkg::SIZE_W-1:0] remainder
);
   import ndis_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0]     div_ff, div_in;
   logic [SIZE_W:0]       rem_shift;
   logic [SIZE_W:0]       rem_diff;
   logic                  ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      ge        = rem_shift >= {1'b0, div_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_diff[SIZE_W-1:0] : rem_shift[SIZE_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/ndis_datapath.sv @@
// ----------------------------------------------------------------------------
// ndis_datapath
// configuration, digit storage, carry divider, global id and result words
// ----------------------------------------------------------------------------
module ndis_datapath #(
   parameter int MAX_DIMS = 3,
   parameter int ID_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ndis_pkg::ndis_cmd_type         cmd,
   output ndis_pkg::ndis_status_type      status,
   input  logic                           csr_valid,
   input  logic [ndis_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [ndis_pkg::SIZE_W-1:0]    csr_data,
   input  logic [ndis_pkg::SIZE_W-1:0]    req_advance,
   output logic [ndis_pkg::SIZE_W-1:0]    out_local [ndis_pkg::CFG_DIMS],
   output logic [ndis_pkg::SIZE_W-1:0]    out_group [ndis_pkg::CFG_DIMS],
   output logic [ndis_pkg::GLOBAL_W-1:0]  out_global [ndis_pkg::CFG_DIMS],
   output logic                           out_past_end
);
   import ndis_pkg::*;

   localparam int BASE_W  = (ID_WIDTH > SIZE_W) ? ID_WIDTH : SIZE_W;
   localparam int CARRY_W = BASE_W + 3;

   logic [1:0]          work_dims_ff;
   logic [SIZE_W-1:0]   lsize_ff [CFG_DIMS];
   logic [SIZE_W-1:0]   gcount_ff [CFG_DIMS];

   logic [ID_WIDTH-1:0] local_ff [MAX_DIMS];
   logic [ID_WIDTH-1:0] group_ff [MAX_DIMS];
   logic                done_ff;
   logic [CARRY_W-1:0]  carry_ff;
   logic [GLOBAL_W-1:0] prod_ff;
   logic [GLOBAL_W-1:0] global_ff [MAX_DIMS];

   logic [SIZE_W-1:0]   res_local_ff [CFG_DIMS];
   logic [SIZE_W-1:0]   res_group_ff [CFG_DIMS];
   logic [GLOBAL_W-1:0] res_global_ff [CFG_DIMS];
   logic                res_done_ff;

   logic [DIM_W-1:0]    dims;
   logic [ID_WIDTH-1:0] sel_local;
   logic [ID_WIDTH-1:0] sel_group;
   logic [SIZE_W-1:0]   sel_lsize;
   logic [SIZE_W-1:0]   sel_gcount;
   logic [ID_WIDTH-1:0] sel_digit;
   logic [SIZE_W-1:0]   sel_radix;
   logic [CARRY_W-1:0]  dividend;
   logic [SIZE_W-1:0]   divisor;
   logic                div_done;
   logic [CARRY_W-1:0]  quotient;
   logic [SIZE_W-1:0]   remainder;
   logic [47:0]         prod_full;
   logic [ID_WIDTH-1:0] local_ext [CFG_DIMS];
   logic [ID_WIDTH-1:0] group_ext [CFG_DIMS];
   logic [GLOBAL_W-1:0] global_ext [CFG_DIMS];

   // active dimension count, clamped to 1..MAX_DIMS
   always_comb begin
      if (work_dims_ff == 2'd0) begin
         dims = 2'd1;
      end else if (work_dims_ff > DIM_W'(MAX_DIMS)) begin
         dims = DIM_W'(MAX_DIMS);
      end else begin
         dims = work_dims_ff;
      end
   end

   always_comb begin
      sel_local  = '0;
      sel_group  = '0;
      sel_lsize  = '0;
      sel_gcount = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (cmd.sel_dim == DIM_W'(i)) begin
            sel_local  = local_ff[i];
            sel_group  = group_ff[i];
            sel_lsize  = lsize_ff[i];
            sel_gcount = gcount_ff[i];
         end
      end
      sel_digit = cmd.sel_group ? sel_group : sel_local;
      sel_radix = cmd.sel_group ? sel_gcount : sel_lsize;
      divisor   = (sel_radix == '0) ? SIZE_W'(1) : sel_radix;
      dividend  = CARRY_W'(sel_digit) + carry_ff;
      prod_full = 48'(GLOBAL_W'(sel_group)) * 48'(sel_lsize);
   end

   ndis_div #(
      .DIVIDEND_W(CARRY_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         work_dims_ff <= 2'd1;
         for (int i = 0; i < CFG_DIMS; i++) begin
            lsize_ff[i]  <= SIZE_W'(1);
            gcount_ff[i] <= SIZE_W'(1);
         end
      end else if (csr_valid) begin
         case (csr_index)
            CFG_WORK_DIMS:     work_dims_ff <= csr_data[1:0];
            CFG_LOCAL_SIZE_X:  lsize_ff[0]  <= csr_data;
            CFG_LOCAL_SIZE_Y:  lsize_ff[1]  <= csr_data;
            CFG_LOCAL_SIZE_Z:  lsize_ff[2]  <= csr_data;
            CFG_GROUP_COUNT_X: gcount_ff[0] <= csr_data;
            CFG_GROUP_COUNT_Y: gcount_ff[1] <= csr_data;
            CFG_GROUP_COUNT_Z: gcount_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // counter digits and past-end flag
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            local_ff[i] <= '0;
            group_ff[i] <= '0;
         end
      end else if (cmd.set_done) begin
         done_ff <= 1'b1;
         for (int i = 0; i < MAX_DIMS; i++) begin
            local_ff[i] <= '0;
            group_ff[i] <= '0;
         end
      end else if (cmd.digit_write) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            if (cmd.sel_dim == DIM_W'(i)) begin
               if (cmd.sel_group) begin
                  group_ff[i] <= ID_WIDTH'(remainder);
               end else begin
                  local_ff[i] <= ID_WIDTH'(remainder);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         carry_ff <= CARRY_W'(req_advance);
      end else if (cmd.digit_write) begin
         carry_ff <= quotient;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full[GLOBAL_W-1:0];
      end
      if (cmd.add) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            if (cmd.sel_dim == DIM_W'(i)) begin
               global_ff[i] <= prod_ff + GLOBAL_W'(local_ff[i]);
            end
         end
      end
   end

   // result word
   always_comb begin
      for (int i = 0; i < CFG_DIMS; i++) begin
         local_ext[i]  = '0;
         group_ext[i]  = '0;
         global_ext[i] = '0;
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
         if ((DIM_W'(i) < dims) && !done_ff) begin
            local_ext[i]  = local_ff[i];
            group_ext[i]  = group_ff[i];
            global_ext[i] = global_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int i = 0; i < CFG_DIMS; i++) begin
            res_local_ff[i]  <= SIZE_W'(local_ext[i]);
            res_group_ff[i]  <= SIZE_W'(group_ext[i]);
            res_global_ff[i] <= global_ext[i];
         end
         res_done_ff <= done_ff;
      end
   end

   assign out_local    = res_local_ff;
   assign out_group    = res_group_ff;
   assign out_global   = res_global_ff;
   assign out_past_end = res_done_ff;

   assign status.carry_zero = (carry_ff == '0);
   assign status.range_done = done_ff;
   assign status.div_done   = div_done;
   assign status.dims       = dims;

endmodule

@@ rtl/ndis_ctrl.sv @@
// ----------------------------------------------------------------------------
// ndis_ctrl
// step sequencer: walks the carry over the digits, then builds global ids
// ----------------------------------------------------------------------------
module ndis_ctrl #(
   parameter int MAX_DIMS = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  ndis_pkg::ndis_status_type status,
   output ndis_pkg::ndis_cmd_type    cmd
);
   import ndis_pkg::*;

   ndis_state_type   state_ff, state_in;
   logic             grp_ff, grp_in;
   logic [DIM_W-1:0] dim_ff, dim_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0] dim_next;
   logic             out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grp_ff       <= 1'b0;
         dim_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grp_ff       <= grp_in;
         dim_ff       <= dim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      grp_in       = grp_ff;
      dim_in       = dim_ff;
      dim_next     = dim_ff + DIM_W'(1);
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.sel_group = grp_ff;
      cmd.sel_dim   = dim_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               grp_in   = 1'b0;
               dim_in   = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.range_done || status.carry_zero) begin
               grp_in   = 1'b1;
               dim_in   = '0;
               state_in = ST_GLOB;
            end else if (grp_ff && (dim_ff == status.dims)) begin
               cmd.set_done = 1'b1;
               dim_in       = '0;
               state_in     = ST_GLOB;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.digit_write = 1'b1;
               if (dim_next == status.dims) begin
                  if (!grp_ff) begin
                     grp_in = 1'b1;
                     dim_in = '0;
                  end else begin
                     dim_in = status.dims;
                  end
               end else begin
                  dim_in = dim_next;
               end
               state_in = ST_STEP;
            end
         end
         ST_GLOB: begin
            cmd.sel_group = 1'b1;
            cmd.mul       = 1'b1;
            state_in      = ST_GADD;
         end
         ST_GADD: begin
            cmd.add = 1'b1;
            if (dim_ff == DIM_W'(MAX_DIMS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               dim_in   = dim_next;
               state_in = ST_GLOB;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/ndrange_index_stepper_core.sv @@
// ----------------------------------------------------------------------------
// ndrange_index_stepper_core
// work-item index generator for a 1 to 3 dimensional dispatch range
//
// req channel: one word carries an advance count; the position, a
// mixed-radix counter of local digits then group digits, steps forward by it.
// rsp channel: one word per request with local, group and global ids per
// dimension and the sticky past-end flag.
// csr channel: csr_ready is always high; index 0 is work_dims, 1..3 the
// local sizes, 4..6 the group counts. Write only while no request is open.
// Each digit the carry reaches costs one division in the bit-serial carry
// divider, which is max(ID_WIDTH, 16) + 3 bits wide; then a product and a
// sum per dimension build the global ids, and the result word is loaded.
// One request is worked at a time, and the next is taken while the
// previous result waits.
// Reset clears the digits and the past-end flag and sets all configuration registers to 1.
// When rsp_stall holds the result, a finished next result waits for it.
// ----------------------------------------------------------------------------
module ndrange_index_stepper_core #(
   parameter int MAX_DIMS = 3,
   parameter int ID_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ndis_pkg::SIZE_W-1:0]    req_advance,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ndis_pkg::SIZE_W-1:0]    rsp_local_id_x,
   output logic [ndis_pkg::SIZE_W-1:0]    rsp_local_id_y,
   output logic [ndis_pkg::SIZE_W-1:0]    rsp_local_id_z,
   output logic [ndis_pkg::SIZE_W-1:0]    rsp_group_id_x,
   output logic [ndis_pkg::SIZE_W-1:0]    rsp_group_id_y,
   output logic [ndis_pkg::SIZE_W-1:0]    rsp_group_id_z,
   output logic [ndis_pkg::GLOBAL_W-1:0]  rsp_global_id_x,
   output logic [ndis_pkg::GLOBAL_W-1:0]  rsp_global_id_y,
   output logic [ndis_pkg::GLOBAL_W-1:0]  rsp_global_id_z,
   output logic                           rsp_past_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ndis_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [ndis_pkg::SIZE_W-1:0]    csr_data
);
   import ndis_pkg::*;

   ndis_cmd_type    cmd;
   ndis_status_type status;
   logic [SIZE_W-1:0]   out_local [CFG_DIMS];
   logic [SIZE_W-1:0]   out_group [CFG_DIMS];
   logic [GLOBAL_W-1:0] out_global [CFG_DIMS];

   assign csr_ready = 1'b1;

   ndis_ctrl #(
      .MAX_DIMS(MAX_DIMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ndis_datapath #(
      .MAX_DIMS(MAX_DIMS),
      .ID_WIDTH(ID_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_advance  (req_advance),
      .out_local    (out_local),
      .out_group    (out_group),
      .out_global   (out_global),
      .out_past_end (rsp_past_end)
   );

   assign rsp_local_id_x  = out_local[0];
   assign rsp_local_id_y  = out_local[1];
   assign rsp_local_id_z  = out_local[2];
   assign rsp_group_id_x  = out_group[0];
   assign rsp_group_id_y  = out_group[1];
   assign rsp_group_id_z  = out_group[2];
   assign rsp_global_id_x = out_global[0];
   assign rsp_global_id_y = out_global[1];
   assign rsp_global_id_z = out_global[2];

endmodule
